### hdl/ssms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssms_pkg;

  localparam int DIGIT_COUNT_DEF = 4;
  localparam int COUNT_W         = 18;
  localparam int FLASH_W         = 16;
  localparam logic [FLASH_W-1:0] FLASH_TICKS_RST = 16'd2000;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_e;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_FLASH  = 2'd1;

  localparam logic [7:0] POINT_MASK = 8'h80;

  // Segment patterns, bit0 segment a; symbol 10 is point only, 11-15 blank.
  localparam logic [7:0] SEG_TABLE [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    kind_e      kind;
    logic [1:0] digit_index;
    logic [3:0] digit_value;
    logic       digit_point;
    logic [1:0] digit_mode;
  } item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       point;
    logic [3:0] value;
  } setting_t;

  typedef struct packed {
    logic [7:0] segment_data;
    logic       segment_load;
  } result_t;

  function automatic logic [7:0] pattern_of(setting_t s);
    logic [7:0] p;
    p = SEG_TABLE[s.value];
    if (s.point) begin
      p = p | POINT_MASK;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### hdl/ssms_scan_core.sv
`timescale 1ns / 1ps
`default_nettype none

module ssms_scan_core #(
  parameter int DIGIT_COUNT = ssms_pkg::DIGIT_COUNT_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 step_i,
  input  wire ssms_pkg::item_t                item_i,
  input  wire logic [ssms_pkg::FLASH_W-1:0]   flash_ticks_i,
  output ssms_pkg::result_t                   result_o,
  output logic [DIGIT_COUNT-1:0]              digit_enables_o
);

  localparam int PHASE_W = $clog2(DIGIT_COUNT + 2);
  localparam int IDX_W   = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [PHASE_W-1:0] PH_BEGIN = '0;
  localparam logic [PHASE_W-1:0] PH_END   = PHASE_W'(DIGIT_COUNT + 1);
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(DIGIT_COUNT - 1);

  logic [PHASE_W-1:0]               phase_q, phase_d;
  logic [ssms_pkg::COUNT_W-1:0]     tick_q, tick_d, tick_inc;
  logic                             blink_q, blink_d;
  logic [DIGIT_COUNT-1:0]           drive_q, drive_d;
  ssms_pkg::setting_t               settings_q [DIGIT_COUNT];
  logic [7:0]                       patterns_q [DIGIT_COUNT];

  logic [IDX_W-1:0] cur_idx, prev_idx, wr_idx;
  logic             wr_hit, do_tick, do_write, in_begin, in_end;
  logic [1:0]       cur_mode;

  assign do_tick  = step_i && (item_i.kind == ssms_pkg::KIND_TICK);
  assign do_write = step_i && (item_i.kind == ssms_pkg::KIND_WRITE);
  assign in_begin = (phase_q == PH_BEGIN);
  assign in_end   = (phase_q == PH_END);
  assign tick_inc = tick_q + 1'b1;
  assign cur_idx  = IDX_W'(phase_q - 1'b1);
  assign prev_idx = (cur_idx == '0) ? LAST_IDX : cur_idx - 1'b1;
  assign wr_idx   = IDX_W'(item_i.digit_index);
  assign wr_hit   = (int'(item_i.digit_index) < DIGIT_COUNT);
  assign cur_mode = settings_q[cur_idx].mode;

  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    blink_d  = blink_q;
    drive_d  = drive_q;
    result_o = '0;
    if (do_tick) begin
      tick_d = tick_inc;
      if (in_begin) begin
        if (tick_inc < {2'b00, flash_ticks_i}) begin
          blink_d = 1'b1;
        end else if (tick_inc < {1'b0, flash_ticks_i, 1'b0}) begin
          blink_d = 1'b0;
        end else begin
          tick_d = '0;
        end
        phase_d = phase_q + 1'b1;
      end else if (in_end) begin
        drive_d[LAST_IDX] = 1'b0;
        phase_d = PH_BEGIN;
      end else begin
        drive_d[prev_idx] = 1'b0;
        result_o.segment_data = patterns_q[cur_idx];
        result_o.segment_load = 1'b1;
        if (cur_mode == ssms_pkg::MODE_NORMAL ||
            (cur_mode == ssms_pkg::MODE_FLASH && blink_q)) begin
          drive_d[cur_idx] = 1'b1;
        end
        phase_d = phase_q + 1'b1;
      end
    end
  end

  assign digit_enables_o = drive_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BEGIN;
      tick_q  <= '0;
      blink_q <= 1'b1;
      drive_q <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      blink_q <= blink_d;
      drive_q <= drive_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        settings_q[i] <= '0;
        patterns_q[i] <= '0;
      end
    end else begin
      if (do_write && wr_hit) begin
        settings_q[wr_idx] <= '{mode: item_i.digit_mode, point: item_i.digit_point,
                                value: item_i.digit_value};
      end
      if (do_tick && in_begin) begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          patterns_q[i] <= ssms_pkg::pattern_of(settings_q[i]);
        end
      end
    end
  end

  // Only one digit is ever driven at a time.
  a_one_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(drive_q))
    else $error("more than one digit driven");

  // A segment byte goes out only in a show phase.
  a_load_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.segment_load |-> (!in_begin && !in_end && do_tick))
    else $error("segment load outside show phase");

  // A tick in the end phase wraps the scan back to the begin phase.
  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_tick && in_end) |=> (phase_q == PH_BEGIN))
    else $error("scan did not wrap");

  // A write leaves the drive lines alone.
  a_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_write |=> (drive_q == $past(drive_q)))
    else $error("write changed drive lines");

endmodule

`default_nettype wire

### hdl/seven_segment_mux_scanner.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel      Dir  tdata (low bit up)                        tuser
// s_axis       in   digit_index[1:0] digit_value[5:2]         kind (0 tick, 1 write)
//                   digit_point[6] digit_mode[8:7], pad to 16
// m_axis       out  segment_data[7:0] digit_enables[+DIGIT_COUNT],  segment_load
//                   pad to whole bytes
// cfg          in   cfg_wdata_i = flash_ticks, written when cfg_we_i is high
//
// One beat per clock while m_axis is ready: a beat is captured in the input
// register, then the scan logic runs on it and the result lands in the output
// register, where m_axis_tvalid is raised for it.
// The input register still takes a beat while the output waits, so a stall on
// m_axis backs up at most one beat before s_axis_tready drops.
// Reset clears the scan phase, tick counter, drive lines, digit settings and
// latched patterns, sets the blink phase on and flash_ticks to 2000.

module seven_segment_mux_scanner #(
  parameter int DIGIT_COUNT = ssms_pkg::DIGIT_COUNT_DEF,
  localparam int OutTdataW  = ((8 + DIGIT_COUNT + 7) / 8) * 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration: flash_ticks
  input  wire                              cfg_we_i,
  input  wire [ssms_pkg::FLASH_W-1:0]      cfg_wdata_i,
  // input stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire [15:0]                       s_axis_tdata,  // index, value, point, mode
  input  wire                              s_axis_tuser,  // kind
  // result stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [OutTdataW-1:0]             m_axis_tdata,  // segment_data, digit_enables
  output logic                             m_axis_tuser   // segment_load
);

  logic [ssms_pkg::FLASH_W-1:0] flash_q;
  logic                         in_valid_q;
  ssms_pkg::item_t              in_item_q;
  logic                         out_valid_q;
  ssms_pkg::result_t            out_res_q;
  logic [DIGIT_COUNT-1:0]       out_en_q;

  ssms_pkg::result_t            core_res;
  logic [DIGIT_COUNT-1:0]       core_en;
  logic                         advance;

  // Move a beat into the scan logic when the output slot is free or draining.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_q <= ssms_pkg::FLASH_TICKS_RST;
    end else if (cfg_we_i) begin
      flash_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold while stalled, no reset needed.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= '{kind:        ssms_pkg::kind_e'(s_axis_tuser),
                     digit_index: s_axis_tdata[1:0],
                     digit_value: s_axis_tdata[5:2],
                     digit_point: s_axis_tdata[6],
                     digit_mode:  s_axis_tdata[8:7]};
    end
    if (advance) begin
      out_res_q <= core_res;
      out_en_q  <= core_en;
    end
  end

  ssms_scan_core #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .item_i          (in_item_q),
    .flash_ticks_i   (flash_q),
    .result_o        (core_res),
    .digit_enables_o (core_en)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTdataW'({out_en_q, out_res_q.segment_data});
  assign m_axis_tuser  = out_res_q.segment_load;

endmodule

`default_nettype wire
